### src/basic_factor_dictionary_defines.svh
// Assertion macros used by the checker of the basic factor dictionary.
`ifndef BASIC_FACTOR_DICTIONARY_DEFINES_SVH
`define BASIC_FACTOR_DICTIONARY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFD_ASSERT_SAME(NAME, CLK, RSTN, A, C) \
    NAME: assert property (@(posedge CLK) disable iff (!(RSTN)) (A) |-> (C)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFD_ASSERT_NEXT(NAME, CLK, RSTN, A, C) \
    NAME: assert property (@(posedge CLK) disable iff (!(RSTN)) (A) |=> (C)) \
        else $error("assertion failed");

`endif

### src/bfd_pkg.sv
// Shared types and codes of the basic factor dictionary.
`default_nettype none
package bfd_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int DATA_W  = 24;
    localparam int FIELD_W = 8;
    localparam int LEVEL_W = 4;

    typedef struct packed {
        logic accept;
        logic ld_commit;
        logic bld_init;
        logic lv_init;
        logic lv_next;
        logic rd_a;
        logic rd_b;
        logic latch_b;
        logic k_next;
        logic dict_rd;
        logic dict_add;
        logic rank_wr;
        logic bld_done;
        logic q_rd_l;
        logic q_rd_r;
        logic q_out;
    } t_bfd_cmd;

    typedef struct packed {
        logic last;
        logic lv_ok;
        logic j_done;
        logic k_end;
        logic match;
        logic clr_busy;
        logic out_free;
    } t_bfd_status;

endpackage
`default_nettype wire

### src/bfd_ctrl.sv
// Controller state machine that sequences loads, the level build and queries.
`default_nettype none
module bfd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  i_cmd_query,
    input  wire bfd_pkg::t_bfd_status i_st,
    output logic                 o_ready,
    output bfd_pkg::t_bfd_cmd    o_cmd
);
    import bfd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_LD_WR    = 12'b0000_0000_0010,
        S_BLD_LV   = 12'b0000_0000_0100,
        S_BLD_J    = 12'b0000_0000_1000,
        S_BLD_A    = 12'b0000_0001_0000,
        S_BLD_B    = 12'b0000_0010_0000,
        S_BLD_SCAN = 12'b0000_0100_0000,
        S_BLD_CMP  = 12'b0000_1000_0000,
        S_BLD_END  = 12'b0001_0000_0000,
        S_Q_L      = 12'b0010_0000_0000,
        S_Q_R      = 12'b0100_0000_0000,
        S_Q_OUT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE) && !i_st.clr_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (o_ready && i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_cmd_query == CMD_QUERY) ? S_Q_L : S_LD_WR;
                end
            end
            S_LD_WR: begin
                o_cmd.ld_commit = 1'b1;
                if (i_st.last) begin
                    o_cmd.bld_init = 1'b1;
                    n_state = S_BLD_LV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BLD_LV: begin
                if (i_st.lv_ok) begin
                    o_cmd.lv_init = 1'b1;
                    n_state = S_BLD_J;
                end else begin
                    n_state = S_BLD_END;
                end
            end
            S_BLD_J: begin
                if (i_st.j_done) begin
                    o_cmd.lv_next = 1'b1;
                    n_state = S_BLD_LV;
                end else begin
                    o_cmd.rd_a = 1'b1;
                    n_state = S_BLD_A;
                end
            end
            S_BLD_A: begin
                o_cmd.rd_b = 1'b1;
                n_state = S_BLD_B;
            end
            S_BLD_B: begin
                o_cmd.latch_b = 1'b1;
                n_state = S_BLD_SCAN;
            end
            S_BLD_SCAN: begin
                if (i_st.k_end) begin
                    o_cmd.dict_add = 1'b1;
                    o_cmd.rank_wr  = 1'b1;
                    n_state = S_BLD_J;
                end else begin
                    o_cmd.dict_rd = 1'b1;
                    n_state = S_BLD_CMP;
                end
            end
            S_BLD_CMP: begin
                if (i_st.match) begin
                    o_cmd.rank_wr = 1'b1;
                    n_state = S_BLD_J;
                end else begin
                    o_cmd.k_next = 1'b1;
                    n_state = S_BLD_SCAN;
                end
            end
            S_BLD_END: begin
                o_cmd.bld_done = 1'b1;
                if (!i_st.clr_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_Q_L: begin
                o_cmd.q_rd_l = 1'b1;
                n_state = S_Q_R;
            end
            S_Q_R: begin
                o_cmd.q_rd_r = 1'b1;
                n_state = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.q_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### src/bfd_datapath.sv
// Datapath with the symbol map, rank table, pair dictionary and output register.
`default_nettype none
module bfd_datapath #(
    parameter int MAX_LEN     = 256,
    parameter int LEVELS      = 9,
    parameter int SYMBOL_BITS = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bfd_pkg::t_bfd_cmd       i_cmd,
    input  wire                          i_cmd_query,
    input  wire                          i_last,
    input  wire  [bfd_pkg::FIELD_W-1:0]  i_sym,
    input  wire  [bfd_pkg::FIELD_W-1:0]  i_qs,
    input  wire  [bfd_pkg::FIELD_W-1:0]  i_qe,
    input  wire                          i_out_ready,
    output bfd_pkg::t_bfd_status         o_st,
    output logic                         o_out_valid,
    output logic [bfd_pkg::FIELD_W-1:0]  o_left,
    output logic [bfd_pkg::FIELD_W-1:0]  o_right,
    output logic [bfd_pkg::LEVEL_W-1:0]  o_level,
    output logic                         o_ok
);
    import bfd_pkg::*;

    localparam int SYM_COUNT = 1 << SYMBOL_BITS;
    localparam int IDW  = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam int LENW = $clog2(MAX_LEN + 1);
    localparam int LVW  = $clog2(LEVELS + 1);
    localparam int RAW  = $clog2(LEVELS * MAX_LEN);
    localparam int CW   = (LEVELS + 1 > LENW + 1) ? LEVELS + 1 : LENW + 1;
    localparam int QW   = (LENW > FIELD_W + 1) ? LENW : FIELD_W + 1;

    logic [IDW:0]       r_map_mem [SYM_COUNT];
    logic [IDW-1:0]     r_rank_mem [LEVELS * MAX_LEN];
    logic [2*IDW-1:0]   r_dict_mem [MAX_LEN];

    logic [IDW:0]       r_map_q;
    logic [IDW-1:0]     r_rank_q;
    logic [2*IDW-1:0]   r_dict_q;

    logic [LENW-1:0]    r_len, r_next, r_j, r_k, r_entries;
    logic               r_built, r_last, r_clr_busy;
    logic [SYMBOL_BITS-1:0] r_clr;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [LVW-1:0]     r_lv;
    logic [IDW-1:0]     r_a, r_b, r_left;
    logic [FIELD_W-1:0] r_qs, r_qe;
    logic [LEVEL_W-1:0] r_p;
    logic               r_qok;

    logic [SYMBOL_BITS-1:0] w_sym;
    logic [CW-1:0]      w_pow, w_n;
    logic [QW-1:0]      w_qlen;
    logic [LEVEL_W-1:0] w_p;
    logic               w_qok;
    logic               w_alloc, w_ld_wr;
    logic [IDW-1:0]     w_ld_id;
    logic               w_rank_we, w_rank_re;
    logic [RAW-1:0]     w_rank_wa, w_rank_ra;
    logic [IDW-1:0]     w_rank_wd;
    logic [FIELD_W:0]   w_rcol;

    function automatic logic [RAW-1:0] rank_addr(input logic [LVW-1:0] row,
                                                 input logic [LENW-1:0] col);
        rank_addr = RAW'(int'(row) * MAX_LEN) + RAW'(col);
    endfunction

    assign w_sym = SYMBOL_BITS'(i_sym);
    assign w_pow = CW'(1) << r_lv;
    assign w_n   = CW'(r_len);

    assign o_st.last     = r_last;
    assign o_st.lv_ok    = (r_lv < LVW'(LEVELS)) && (w_pow <= w_n);
    assign o_st.j_done   = (CW'(r_j) + w_pow) == (w_n + CW'(1));
    assign o_st.k_end    = (r_k == r_entries);
    assign o_st.match    = (r_dict_q == {r_a, r_b});
    assign o_st.clr_busy = r_clr_busy;
    assign o_st.out_free = !o_out_valid || i_out_ready;

    always_comb begin
        w_qlen = QW'(i_qe) - QW'(i_qs) + QW'(1);
        w_p = '0;
        for (int i = 0; i <= FIELD_W; i++) begin
            if (w_qlen[i]) begin
                w_p = LEVEL_W'(i);
            end
        end
        if (int'(w_p) > LEVELS - 1) begin
            w_p = LEVEL_W'(LEVELS - 1);
        end
        w_qok = r_built && (i_qs <= i_qe) && (QW'(i_qe) < QW'(r_len));
    end

    assign w_ld_wr = i_cmd.ld_commit && (r_len < LENW'(MAX_LEN));
    assign w_alloc = w_ld_wr && !r_map_q[IDW];
    assign w_ld_id = r_map_q[IDW] ? r_map_q[IDW-1:0] : r_next[IDW-1:0];
    assign w_rcol  = {1'b0, r_qe} + (FIELD_W+1)'(1) - ((FIELD_W+1)'(1) << r_p);

    always_comb begin
        w_rank_we = w_ld_wr || i_cmd.rank_wr;
        if (w_ld_wr) begin
            w_rank_wa = rank_addr('0, r_len);
            w_rank_wd = w_ld_id;
        end else begin
            w_rank_wa = rank_addr(r_lv, r_j);
            w_rank_wd = r_k[IDW-1:0];
        end
        w_rank_re = i_cmd.rd_a || i_cmd.rd_b || i_cmd.q_rd_l || i_cmd.q_rd_r;
        if (i_cmd.rd_a) begin
            w_rank_ra = rank_addr(r_lv - LVW'(1), r_j);
        end else if (i_cmd.rd_b) begin
            w_rank_ra = rank_addr(r_lv - LVW'(1), r_j + LENW'(w_pow >> 1));
        end else if (i_cmd.q_rd_l) begin
            w_rank_ra = rank_addr(LVW'(r_p), LENW'(r_qs));
        end else begin
            w_rank_ra = rank_addr(LVW'(r_p), LENW'(w_rcol));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_map_mem[r_clr] <= '0;
        end else if (w_alloc) begin
            r_map_mem[r_sym] <= {1'b1, r_next[IDW-1:0]};
        end
        if (i_cmd.accept) begin
            r_map_q <= r_map_mem[w_sym];
        end
        if (w_rank_we) begin
            r_rank_mem[w_rank_wa] <= w_rank_wd;
        end
        if (w_rank_re) begin
            r_rank_q <= r_rank_mem[w_rank_ra];
        end
        if (i_cmd.dict_add) begin
            r_dict_mem[r_entries[IDW-1:0]] <= {r_a, r_b};
        end
        if (i_cmd.dict_rd) begin
            r_dict_q <= r_dict_mem[r_k[IDW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym  <= w_sym;
            r_last <= i_last;
            r_qs   <= i_qs;
            r_qe   <= i_qe;
            r_p    <= w_p;
            r_qok  <= w_qok;
        end
        if (i_cmd.lv_init) begin
            r_j       <= '0;
            r_entries <= '0;
        end
        if (i_cmd.rank_wr) begin
            r_j <= r_j + LENW'(1);
        end
        if (i_cmd.dict_add) begin
            r_entries <= r_entries + LENW'(1);
        end
        if (i_cmd.bld_init) begin
            r_lv <= LVW'(1);
        end else if (i_cmd.lv_next) begin
            r_lv <= r_lv + LVW'(1);
        end
        if (i_cmd.rd_b) begin
            r_a <= r_rank_q;
        end
        if (i_cmd.latch_b) begin
            r_b <= r_rank_q;
            r_k <= '0;
        end else if (i_cmd.k_next) begin
            r_k <= r_k + LENW'(1);
        end
        if (i_cmd.q_rd_r) begin
            r_left <= r_rank_q;
        end
        if (i_cmd.q_out) begin
            o_left  <= r_qok ? FIELD_W'(r_left) : '0;
            o_right <= r_qok ? FIELD_W'(r_rank_q) : '0;
            o_level <= r_qok ? r_p : '0;
            o_ok    <= r_qok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_next      <= '0;
            r_built     <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && (i_cmd_query == CMD_LOAD) && r_built) begin
                r_len   <= '0;
                r_next  <= '0;
                r_built <= 1'b0;
            end
            if (w_ld_wr) begin
                r_len <= r_len + LENW'(1);
            end
            if (w_alloc) begin
                r_next <= r_next + LENW'(1);
            end
            if (i_cmd.bld_done) begin
                r_built <= 1'b1;
            end
            if (i_cmd.bld_init) begin
                r_clr_busy <= 1'b1;
                r_clr      <= '0;
            end else if (r_clr_busy) begin
                r_clr <= r_clr + SYMBOL_BITS'(1);
                if (r_clr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cmd.q_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

### src/basic_factor_dictionary.sv
// Top level of the Karp-Miller-Rosenberg basic factor dictionary.
// The slave stream takes one transaction per item. tuser selects the kind: a load
// appends the symbol in tdata[7:0] to the string, and tlast on a load marks the
// last symbol and starts the build of all levels. A query carries the start and
// end positions in tdata[15:8] and tdata[23:16] and yields one master transaction
// with the left and right window ids, the level, and query_ok in tuser.
// A load reads the symbol map, then writes the rank table. A query reads the
// rank of the left window, then of the right window, then writes the output
// register, and the block takes a new item once the result is written. The
// build walks each level window by window; every window reads its two halves
// and scans the pair dictionary entry by entry, adding a new pair on no match.
// Reset clears the string, the table state and the output valid, then a clearing
// pass empties every entry of the symbol map while tready stays low; the
// same pass runs alongside each build. A stalled receiver holds the result in
// the output register; the next load is still taken, a next query is taken but
// holds the block until the output register frees.
`default_nettype none
module basic_factor_dictionary #(
    parameter int MAX_LEN     = 256,
    parameter int LEVELS      = 9,
    parameter int SYMBOL_BITS = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // symbol[7:0], query_start[15:8], query_end[23:16]
    input  wire  [bfd_pkg::DATA_W-1:0]   i_s_axis_tdata,
    // command[0]
    input  wire                          i_s_axis_tuser,
    input  wire                          i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    // left_id[7:0], right_id[15:8], level[19:16], zero[23:20]
    output logic [bfd_pkg::DATA_W-1:0]   o_m_axis_tdata,
    // query_ok[0]
    output logic                         o_m_axis_tuser
);
    import bfd_pkg::*;

    t_bfd_cmd           w_cmd;
    t_bfd_status        w_st;
    logic [FIELD_W-1:0] w_left, w_right;
    logic [LEVEL_W-1:0] w_level;

    bfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_cmd_query (i_s_axis_tuser),
        .i_st        (w_st),
        .o_ready     (o_s_axis_tready),
        .o_cmd       (w_cmd)
    );

    bfd_datapath #(
        .MAX_LEN     (MAX_LEN),
        .LEVELS      (LEVELS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_query (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .i_sym       (i_s_axis_tdata[7:0]),
        .i_qs        (i_s_axis_tdata[15:8]),
        .i_qe        (i_s_axis_tdata[23:16]),
        .i_out_ready (i_m_axis_tready),
        .o_st        (w_st),
        .o_out_valid (o_m_axis_tvalid),
        .o_left      (w_left),
        .o_right     (w_right),
        .o_level     (w_level),
        .o_ok        (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'b0000, w_level, w_right, w_left};

endmodule
`default_nettype wire

### src/bfd_checker.sv
// Port-level checker of the basic factor dictionary and its bind statement.
`default_nettype none
`include "basic_factor_dictionary_defines.svh"
module bfd_checker #(
    parameter int LEVELS = 9
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire [23:0] i_s_axis_tdata,
    input wire        i_s_axis_tuser,
    input wire        i_s_axis_tlast,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [23:0] o_m_axis_tdata,
    input wire        o_m_axis_tuser
);
    import bfd_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    `BFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `BFD_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == 24'd0)
    `BFD_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_in_acc && (i_s_axis_tuser == CMD_LOAD), !o_s_axis_tready)
    `BFD_ASSERT_SAME(a_level_max, i_clk, i_rst_n, o_m_axis_tvalid, int'(o_m_axis_tdata[19:16]) <= LEVELS - 1)

endmodule

bind basic_factor_dictionary bfd_checker #(.LEVELS(LEVELS)) u_bfd_checker (.*);
`default_nettype wire

### tb/sv/tb_basic_factor_dictionary.sv
// Self-checking testbench of the basic factor dictionary: random loads, builds and queries.
`timescale 1ns / 100ps
`default_nettype none

module tb_basic_factor_dictionary;
    import bfd_pkg::*;

    localparam int MAX_LEN   = 256;
    localparam int LEVELS    = 9;
    localparam int IDLE_MAX  = 2000000;

    typedef struct packed {
        logic [7:0] left_id;
        logic [7:0] right_id;
        logic [3:0] level;
        logic       query_ok;
    } t_answer;

    class kmr_scoreboard;
        int          str_len;
        bit          built;
        bit          sym_seen [256];
        int          sym_id [256];
        int          next_id;
        int          rank [LEVELS][MAX_LEN];
        t_answer     pending [$];
        int          errors;

        function void clear_string();
            str_len = 0;
            built = 0;
            next_id = 0;
            foreach (sym_seen[i]) sym_seen[i] = 0;
        endfunction

        function void build_levels();
            int pa [MAX_LEN];
            int pb [MAX_LEN];
            int cnt;
            int k;
            for (int lv = 1; lv < LEVELS && (1 << lv) <= str_len; lv++) begin
                cnt = 0;
                for (int j = 0; j <= str_len - (1 << lv); j++) begin
                    int a;
                    int b;
                    a = rank[lv-1][j];
                    b = rank[lv-1][j + (1 << (lv-1))];
                    for (k = 0; k < cnt; k++)
                        if (pa[k] == a && pb[k] == b) break;
                    if (k == cnt) begin
                        pa[cnt] = a;
                        pb[cnt] = b;
                        cnt++;
                    end
                    rank[lv][j] = k;
                end
            end
            built = 1;
        endfunction

        function void note_item(logic cmd, logic [23:0] data, logic last);
            t_answer ans;
            int s;
            int e;
            int p;
            if (cmd == CMD_LOAD) begin
                if (built) clear_string();
                if (str_len < MAX_LEN) begin
                    if (!sym_seen[data[7:0]]) begin
                        sym_seen[data[7:0]] = 1;
                        sym_id[data[7:0]] = next_id++;
                    end
                    rank[0][str_len] = sym_id[data[7:0]];
                    str_len++;
                end
                if (last) build_levels();
            end else begin
                ans = '0;
                s = int'(data[15:8]);
                e = int'(data[23:16]);
                if (built && s <= e && e < str_len) begin
                    p = 0;
                    while (p + 1 < LEVELS && ((e - s + 1) >> (p + 1)) != 0) p++;
                    ans.left_id  = 8'(rank[p][s]);
                    ans.right_id = 8'(rank[p][e + 1 - (1 << p)]);
                    ans.level    = 4'(p);
                    ans.query_ok = 1'b1;
                end
                pending.push_back(ans);
            end
        endfunction

        function void check_answer(logic [23:0] data, logic ok);
            t_answer exp_ans;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            exp_ans = pending.pop_front();
            if (data[7:0] !== exp_ans.left_id) begin
                $error("left_id expected %0d got %0d", exp_ans.left_id, data[7:0]);
                errors++;
            end
            if (data[15:8] !== exp_ans.right_id) begin
                $error("right_id expected %0d got %0d", exp_ans.right_id, data[15:8]);
                errors++;
            end
            if (data[19:16] !== exp_ans.level) begin
                $error("level expected %0d got %0d", exp_ans.level, data[19:16]);
                errors++;
            end
            if (ok !== exp_ans.query_ok) begin
                $error("query_ok expected %0d got %0d", exp_ans.query_ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [23:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        i_s_axis_tlast = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    kmr_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  sink_on = 0;
    int  cur_len = 0;

    basic_factor_dictionary u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .i_s_axis_tlast(i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && ((i_s_axis_tvalid && o_s_axis_tready) ||
                        (o_m_axis_tvalid && i_m_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_item(i_s_axis_tuser, i_s_axis_tdata, i_s_axis_tlast);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_answer(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin : sink
        int g;
        wait (sink_on);
        forever begin
            g = gap_len();
            i_m_axis_tready <= (g == 0);
            repeat (g == 0 ? $urandom_range(1, 8) : g) @(posedge i_clk);
        end
    end

    task automatic send_item(logic cmd, logic [7:0] sym, logic last,
                             logic [7:0] qs, logic [7:0] qe);
        repeat (gap_len()) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tlast  <= last;
        i_s_axis_tdata  <= {qe, qs, sym};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_string(int n, int alpha);
        for (int i = 0; i < n; i++)
            send_item(CMD_LOAD, 8'($urandom_range(0, alpha - 1)), i == n - 1,
                      8'($urandom), 8'($urandom));
        cur_len = (n > MAX_LEN) ? MAX_LEN : n;
    endtask

    task automatic query(int s, int e);
        send_item(CMD_QUERY, 8'($urandom), 1'($urandom), 8'(s), 8'(e));
    endtask

    task automatic random_query();
        int s;
        int e;
        if ($urandom_range(0, 9) < 8 && cur_len > 0) begin
            s = $urandom_range(0, cur_len - 1);
            e = $urandom_range(s, cur_len - 1);
        end else begin
            s = $urandom_range(0, 255);
            e = $urandom_range(0, 255);
        end
        query(s, e);
    endtask

    initial begin
        fork
            begin
                wait (idle_cycles >= IDLE_MAX);
                $display("Simulation FAILED");
                $finish;
            end
        join_none
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_on = 1;

        query(0, 0);
        send_item(CMD_LOAD, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'hff, 1'b0, 8'hff, 8'hff);
        send_item(CMD_LOAD, 8'h00, 1'b0, 8'h00, 8'h00);
        send_item(CMD_LOAD, 8'hff, 1'b1, 8'hff, 8'hff);
        cur_len = 4;
        query(0, 3);
        query(1, 2);
        query(2, 1);
        query(0, 4);
        query(255, 255);
        query(3, 3);
        load_string(1, 4);
        query(0, 0);
        load_string(260, 256);
        query(0, 255);
        query(1, 255);
        query(0, 127);
        query(100, 100);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        for (int items = 0; items < 470; ) begin
            int n;
            int q;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 256)
                                             : $urandom_range(1, 24);
            load_string(n, $urandom_range(0, 1) ? 2 : $urandom_range(1, 256));
            q = $urandom_range(3, 15);
            items += n + q;
            for (int i = 0; i < q; i++) random_query();
            if ($urandom_range(0, 7) == 0) begin
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
